// ===== sv/sdsm_pkg.sv =====
// Shared types, codes and constants for the SD SPI shared-memory host.
// No dependencies; imported by sdsm_step, the top level and the testbench.
`default_nettype none
package sdsm_pkg;

  localparam logic [9:0] BlockBytes   = 10'd512;
  localparam logic [9:0] PowerUpBytes = 10'd10;
  localparam logic [9:0] BlockLast    = 10'd513;
  localparam logic [9:0] BlockCrcEnd  = 10'd514;

  localparam logic FuncStart = 1'b0;
  localparam logic FuncDone  = 1'b1;

  localparam logic [1:0] OpInit  = 2'd0;
  localparam logic [1:0] OpWrite = 2'd1;
  localparam logic [1:0] OpRead  = 2'd2;

  localparam logic [5:0] CmdGoIdle     = 6'd0;
  localparam logic [5:0] CmdSendIfCond = 6'd8;
  localparam logic [5:0] CmdReadBlock  = 6'd17;
  localparam logic [5:0] CmdWriteBlock = 6'd24;
  localparam logic [5:0] CmdSendOpCond = 6'd41;
  localparam logic [5:0] CmdAppCmd     = 6'd55;

  localparam logic [7:0] ByteIdle     = 8'hFF;
  localparam logic [7:0] ByteToken    = 8'hFE;
  localparam logic [7:0] ByteEcho     = 8'hAA;
  localparam logic [7:0] ByteR1Idle   = 8'h01;
  localparam logic [4:0] DataRespOk   = 5'h05;

  typedef enum logic [3:0] {
    PhIdle,
    PhPwr,
    PhRelNext,
    PhCmdPre,
    PhCmdBytes,
    PhPollR1,
    PhR7,
    PhWrBlock,
    PhWrResp,
    PhWrBusy,
    PhRdWait,
    PhRdData,
    PhRelDone
  } phase_t;

  typedef enum logic [2:0] {
    StOk,
    StCmd0Fail,
    StCmd8Fail,
    StEchoBad,
    StRange,
    StCmdRejected,
    StDataRejected
  } status_t;

  typedef struct packed {
    phase_t     phase;
    logic [9:0] byte_count;
    logic [5:0] cmd;
    logic [8:0] offset;
    logic [9:0] length;
    logic       sel;
  } ctx_t;

  typedef struct packed {
    logic [7:0] mosi_byte;
    logic       mosi_valid;
    logic       cs_level;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       need_data;
    logic       done_res;
    status_t    status;
  } res_t;

  function automatic logic [31:0] cmd_arg(input logic [5:0] cmd, input logic [8:0] off,
                                          input logic [9:0] len);
    logic [16:0] blk;
    logic [8:0]  cnt;
    blk = 17'h01000 + {8'b0, off};
    cnt = len[8:0] - 9'd1;
    if (cmd == CmdSendIfCond) return 32'h0000_01AA;
    if (cmd == CmdSendOpCond) return 32'h4000_0000;
    if (cmd == CmdWriteBlock || cmd == CmdReadBlock) return {6'b100100, blk, cnt};
    return 32'h0;
  endfunction

  // k: 0 opcode, 1..4 argument MSB first, 5 crc
  function automatic logic [7:0] cmd_byte(input logic [5:0] cmd, input logic [2:0] k,
                                          input logic [31:0] arg);
    logic [7:0] b;
    case (k)
      3'd0:    b = {2'b01, cmd};
      3'd1:    b = arg[31:24];
      3'd2:    b = arg[23:16];
      3'd3:    b = arg[15:8];
      3'd4:    b = arg[7:0];
      default: begin
        if (cmd == CmdGoIdle) b = 8'h95;
        else if (cmd == CmdSendIfCond) b = 8'h87;
        else b = 8'h01;
      end
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== sv/sdsm_step.sv =====
// Next-state and result logic for one beat of the SD SPI host sequencer.
// Depends on sdsm_pkg.
`default_nettype none
module sdsm_step (
  input  var sdsm_pkg::ctx_t cur,
  input  wire                func,
  input  wire  [1:0]         op,
  input  wire  [8:0]         addr,
  input  wire  [9:0]         len,
  input  wire  [7:0]         miso_byte,
  input  wire  [7:0]         write_byte,
  output sdsm_pkg::ctx_t     nxt,
  output sdsm_pkg::res_t     res
);
  import sdsm_pkg::*;

  logic [31:0] arg;
  logic [9:0]  bc_inc;
  logic [10:0] end_addr;

  assign arg      = cmd_arg(cur.cmd, cur.offset, cur.length);
  assign bc_inc   = cur.byte_count + 10'd1;
  assign end_addr = {2'b0, addr} + {1'b0, len};

  always_comb begin
    nxt = cur;
    res = '0;
    res.status = StOk;
    if (func == FuncStart) begin
      if (cur.phase == PhIdle) begin
        nxt.offset = addr;
        nxt.length = len;
        if (op == OpInit) begin
          nxt.sel = 1'b0;
          nxt.byte_count = '0;
          nxt.phase = PhPwr;
          res.mosi_byte = ByteIdle;
          res.mosi_valid = 1'b1;
        end else if ((op != OpWrite && op != OpRead) || len == '0
                     || end_addr > {1'b0, BlockBytes}) begin
          res.done_res = 1'b1;
          res.status = StRange;
        end else begin
          nxt.cmd = (op == OpWrite) ? CmdWriteBlock : CmdReadBlock;
          nxt.phase = PhCmdPre;
          res.mosi_byte = ByteIdle;
          res.mosi_valid = 1'b1;
        end
      end
    end else if (cur.phase != PhIdle) begin
      res.mosi_byte = ByteIdle;
      res.mosi_valid = 1'b1;
      unique case (cur.phase)
        PhPwr: begin
          nxt.byte_count = bc_inc;
          if (bc_inc >= PowerUpBytes) begin
            nxt.sel = 1'b1;
            nxt.cmd = CmdGoIdle;
            nxt.phase = PhRelNext;
          end
        end
        PhRelNext: nxt.phase = PhCmdPre;
        PhCmdPre: begin
          nxt.sel = 1'b0;
          nxt.byte_count = '0;
          nxt.phase = PhCmdBytes;
          res.mosi_byte = cmd_byte(cur.cmd, 3'd0, arg);
        end
        PhCmdBytes: begin
          nxt.byte_count = bc_inc;
          if (bc_inc < 10'd6) res.mosi_byte = cmd_byte(cur.cmd, bc_inc[2:0], arg);
          else nxt.phase = PhPollR1;
        end
        PhPollR1: begin
          if (miso_byte != ByteIdle) begin
            case (cur.cmd)
              CmdGoIdle: begin
                if (miso_byte != ByteR1Idle) begin
                  res.mosi_valid = 1'b0;
                  res.done_res = 1'b1;
                  res.status = StCmd0Fail;
                  nxt.phase = PhIdle;
                end else begin
                  nxt.sel = 1'b1;
                  nxt.cmd = CmdSendIfCond;
                  nxt.phase = PhRelNext;
                end
              end
              CmdSendIfCond: begin
                if (miso_byte != ByteR1Idle) begin
                  res.mosi_valid = 1'b0;
                  res.done_res = 1'b1;
                  res.status = StCmd8Fail;
                  nxt.phase = PhIdle;
                end else begin
                  nxt.byte_count = '0;
                  nxt.phase = PhR7;
                end
              end
              CmdAppCmd: begin
                nxt.cmd = CmdSendOpCond;
                nxt.phase = PhCmdPre;
              end
              CmdSendOpCond: begin
                nxt.sel = 1'b1;
                if (miso_byte != 8'h00) begin
                  nxt.cmd = CmdAppCmd;
                  nxt.phase = PhRelNext;
                end else begin
                  nxt.phase = PhRelDone;
                end
              end
              CmdWriteBlock: begin
                if (miso_byte != 8'h00) begin
                  res.mosi_valid = 1'b0;
                  res.done_res = 1'b1;
                  res.status = StCmdRejected;
                  nxt.phase = PhIdle;
                end else begin
                  nxt.phase = PhWrBlock;
                  nxt.byte_count = '0;
                  res.mosi_byte = ByteToken;
                  res.need_data = (cur.length != '0);
                end
              end
              CmdReadBlock: begin
                if (miso_byte != 8'h00) begin
                  res.mosi_valid = 1'b0;
                  res.done_res = 1'b1;
                  res.status = StCmdRejected;
                  nxt.phase = PhIdle;
                end else begin
                  nxt.phase = PhRdWait;
                end
              end
              default: begin
                res.mosi_valid = 1'b0;
                res.done_res = 1'b1;
                res.status = StCmdRejected;
                nxt.phase = PhIdle;
              end
            endcase
          end
        end
        PhR7: begin
          if (cur.byte_count >= 10'd3) begin
            if (miso_byte != ByteEcho) begin
              res.mosi_valid = 1'b0;
              res.done_res = 1'b1;
              res.status = StEchoBad;
              nxt.phase = PhIdle;
            end else begin
              nxt.sel = 1'b1;
              nxt.cmd = CmdAppCmd;
              nxt.phase = PhRelNext;
            end
          end else begin
            nxt.byte_count = bc_inc;
          end
        end
        PhWrBlock: begin
          if (cur.byte_count >= BlockCrcEnd) begin
            nxt.phase = PhWrResp;
          end else begin
            nxt.byte_count = bc_inc;
            if (bc_inc <= BlockBytes && bc_inc <= cur.length) res.mosi_byte = write_byte;
            res.need_data = (bc_inc < BlockBytes) && (bc_inc < cur.length);
          end
        end
        PhWrResp: begin
          if (miso_byte[4:0] != DataRespOk) begin
            res.mosi_valid = 1'b0;
            res.done_res = 1'b1;
            res.status = StDataRejected;
            nxt.phase = PhIdle;
          end else begin
            nxt.phase = PhWrBusy;
          end
        end
        PhWrBusy: begin
          if (miso_byte != 8'h00) begin
            nxt.sel = 1'b1;
            nxt.phase = PhRelDone;
          end
        end
        PhRdWait: begin
          if (miso_byte == ByteToken) begin
            nxt.byte_count = '0;
            nxt.phase = PhRdData;
          end
        end
        PhRdData: begin
          if (cur.byte_count < cur.length) begin
            res.read_byte = miso_byte;
            res.read_valid = 1'b1;
          end
          if (cur.byte_count >= BlockLast) begin
            nxt.sel = 1'b1;
            nxt.phase = PhRelDone;
          end else begin
            nxt.byte_count = bc_inc;
          end
        end
        PhRelDone: begin
          res.mosi_valid = 1'b0;
          res.mosi_byte = '0;
          res.done_res = 1'b1;
          res.status = StOk;
          nxt.phase = PhIdle;
        end
        default: begin
          res.mosi_valid = 1'b0;
          res.mosi_byte = '0;
          nxt.phase = PhIdle;
        end
      endcase
      if (!res.mosi_valid) res.mosi_byte = '0;
    end
    res.cs_level = nxt.sel;
  end

endmodule
`default_nettype wire

// ===== sv/sd_spi_shared_memory_host.sv =====
// Top level of the SD SPI-mode shared-memory host sequencer.
// Depends on sdsm_pkg and sdsm_step.
//
// One beat in gives one beat out. A start beat (func 0) launches init, block write or
// block read; each later beat (func 1) reports the byte just clocked on MISO and yields
// the next MOSI byte, chip select level, read data, a need_data request or a done with
// status. A beat is taken every cycle as long as the result register is empty or is being
// drained; its result is registered and shows in the next cycle. The sequencer state and
// the result register are the only storage: one beat per clock unless the output stalls.
`default_nettype none
module sd_spi_shared_memory_host (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire        in_func,
  input  wire  [1:0] in_op,
  input  wire  [8:0] in_addr,
  input  wire  [9:0] in_len,
  input  wire  [7:0] in_miso_byte,
  input  wire  [7:0] in_write_byte,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [7:0] out_mosi_byte,
  output logic       out_mosi_valid,
  output logic       out_cs_level,
  output logic [7:0] out_read_byte,
  output logic       out_read_valid,
  output logic       out_need_data,
  output logic       out_done_res,
  output logic [2:0] out_status
);
  import sdsm_pkg::*;

  ctx_t ctx_r, ctx_nxt;
  res_t res_r, res_nxt;
  logic out_valid_r;
  logic accept;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  sdsm_step u_step (
    .cur        (ctx_r),
    .func       (in_func),
    .op         (in_op),
    .addr       (in_addr),
    .len        (in_len),
    .miso_byte  (in_miso_byte),
    .write_byte (in_write_byte),
    .nxt        (ctx_nxt),
    .res        (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r <= '{phase: PhIdle, byte_count: '0, cmd: '0, offset: '0, length: '0, sel: 1'b1};
      out_valid_r <= 1'b0;
    end else begin
      if (accept) ctx_r <= ctx_nxt;
      if (accept) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) res_r <= res_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_mosi_byte  = res_r.mosi_byte;
  assign out_mosi_valid = res_r.mosi_valid;
  assign out_cs_level   = res_r.cs_level;
  assign out_read_byte  = res_r.read_byte;
  assign out_read_valid = res_r.read_valid;
  assign out_need_data  = res_r.need_data;
  assign out_done_res   = res_r.done_res;
  assign out_status     = res_r.status;

endmodule
`default_nettype wire

// ===== sv/sdsm_checker.sv =====
// Port-level checks for sd_spi_shared_memory_host, bound to the top level.
// Depends only on the top-level port list.
`default_nettype none
module sdsm_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       out_valid,
  input wire       out_ready,
  input wire [7:0] out_mosi_byte,
  input wire       out_mosi_valid,
  input wire       out_cs_level,
  input wire       out_read_valid,
  input wire       out_need_data,
  input wire       out_done_res
);

  // read data only arrives alongside the next clocked byte
  a_read_has_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_valid |-> out_mosi_valid)
    else $error("read beat without exchange");

  // a finished operation never starts another exchange
  a_done_no_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_mosi_valid)
    else $error("done beat with exchange");

  // write data is only requested for a selected block byte
  a_need_selected: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_need_data |-> out_mosi_valid && !out_cs_level)
    else $error("need_data outside a selected exchange");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mosi_byte))
    else $error("result beat dropped or changed while stalled");

endmodule

bind sd_spi_shared_memory_host sdsm_checker u_sdsm_checker (.*);
`default_nettype wire

// ===== tb/tb_sd_spi_shared_memory_host.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sd_spi_shared_memory_host: a scoreboard class predicts
// every result beat, while a small card responder shapes MISO replies from that state.
// Depends on sdsm_pkg and the RTL of the block.
module tb_sd_spi_shared_memory_host;
  import sdsm_pkg::*;

  localparam logic [1:0] OpUnused  = 2'd3;
  localparam logic [7:0] R1Ready   = 8'h00;
  localparam logic [7:0] CardBusy  = 8'h00;
  localparam logic [7:0] CrcGoIdle = 8'h95;
  localparam logic [7:0] CrcIfCond = 8'h87;
  localparam logic [7:0] CrcOther  = 8'h01;
  localparam int         ItemCount = 500;

  typedef struct packed {
    logic       func;
    logic [1:0] op;
    logic [8:0] addr;
    logic [9:0] len;
    logic [7:0] miso;
    logic [7:0] wb;
  } host_beat_t;

  class sdsm_scoreboard;
    phase_t     ph;
    logic [9:0] cnt;
    logic [5:0] cmd;
    logic [8:0] offset;
    logic [9:0] length;
    logic       sel;
    res_t       nxt;
    res_t       expected_replies[$];
    int         errors;
    int         checked;

    function new();
      ph = PhIdle;
      cnt = '0;
      cmd = '0;
      offset = '0;
      length = '0;
      sel = 1'b1;
      errors = 0;
      checked = 0;
    endfunction

    function void send_byte(logic [7:0] b);
      nxt.mosi_byte = b;
      nxt.mosi_valid = 1'b1;
    endfunction

    function void end_op(status_t st);
      ph = PhIdle;
      nxt.done_res = 1'b1;
      nxt.status = st;
    endfunction

    function void release_then(logic [5:0] c);
      sel = 1'b1;
      cmd = c;
      ph = PhRelNext;
      send_byte(ByteIdle);
    endfunction

    function void release_done();
      sel = 1'b1;
      ph = PhRelDone;
      send_byte(ByteIdle);
    endfunction

    function logic [31:0] command_arg();
      logic [31:0] blk;
      if (cmd == CmdSendIfCond) return 32'h0000_01AA;
      if (cmd == CmdSendOpCond) return 32'h4000_0000;
      if (cmd == CmdWriteBlock || cmd == CmdReadBlock) begin
        blk = (32'h1000 + {23'd0, offset}) & 32'h1FFFF;
        return 32'h9000_0000 | (blk << 9) | (({22'd0, length} - 32'd1) & 32'h1FF);
      end
      return 32'd0;
    endfunction

    function logic [7:0] frame_byte(logic [9:0] k);
      logic [31:0] a;
      a = command_arg();
      case (k)
        10'd0: return {2'b01, cmd};
        10'd1: return a[31:24];
        10'd2: return a[23:16];
        10'd3: return a[15:8];
        10'd4: return a[7:0];
        default: begin
          if (cmd == CmdGoIdle) return CrcGoIdle;
          if (cmd == CmdSendIfCond) return CrcIfCond;
          return CrcOther;
        end
      endcase
    endfunction

    // e: 0 start token, 1..512 data, then the two CRC bytes
    function void block_byte(logic [9:0] e, logic [7:0] wb);
      cnt = e;
      if (e == 10'd0) send_byte(ByteToken);
      else if (e <= BlockBytes) send_byte(((e - 10'd1) < length) ? wb : ByteIdle);
      else send_byte(ByteIdle);
      nxt.need_data = ((e + 10'd1) <= BlockBytes) && (e < length);
    endfunction

    function void on_r1(logic [7:0] r);
      case (cmd)
        CmdGoIdle: begin
          if (r != ByteR1Idle) end_op(StCmd0Fail);
          else release_then(CmdSendIfCond);
        end
        CmdSendIfCond: begin
          if (r != ByteR1Idle) end_op(StCmd8Fail);
          else begin
            cnt = '0;
            ph = PhR7;
            send_byte(ByteIdle);
          end
        end
        CmdAppCmd: begin
          cmd = CmdSendOpCond;
          ph = PhCmdPre;
          send_byte(ByteIdle);
        end
        CmdSendOpCond: begin
          if (r != R1Ready) release_then(CmdAppCmd);
          else release_done();
        end
        CmdWriteBlock: begin
          if (r != R1Ready) end_op(StCmdRejected);
          else begin
            ph = PhWrBlock;
            block_byte(10'd0, 8'd0);
          end
        end
        CmdReadBlock: begin
          if (r != R1Ready) end_op(StCmdRejected);
          else begin
            ph = PhRdWait;
            send_byte(ByteIdle);
          end
        end
        default: end_op(StCmdRejected);
      endcase
    endfunction

    function void on_start(logic [1:0] op, logic [8:0] addr, logic [9:0] len);
      offset = addr;
      length = len;
      if (op == OpInit) begin
        sel = 1'b0;
        cnt = '0;
        ph = PhPwr;
        send_byte(ByteIdle);
      end else if (op == OpUnused || len == 10'd0 ||
                   ({2'b0, addr} + {1'b0, len}) > {1'b0, BlockBytes}) begin
        end_op(StRange);
      end else begin
        cmd = (op == OpWrite) ? CmdWriteBlock : CmdReadBlock;
        ph = PhCmdPre;
        send_byte(ByteIdle);
      end
    endfunction

    function void on_done(logic [7:0] m, logic [7:0] wb);
      case (ph)
        PhPwr: begin
          cnt = cnt + 10'd1;
          if (cnt < PowerUpBytes) send_byte(ByteIdle);
          else release_then(CmdGoIdle);
        end
        PhRelNext: begin
          ph = PhCmdPre;
          send_byte(ByteIdle);
        end
        PhCmdPre: begin
          sel = 1'b0;
          cnt = '0;
          ph = PhCmdBytes;
          send_byte(frame_byte(10'd0));
        end
        PhCmdBytes: begin
          cnt = cnt + 10'd1;
          if (cnt < 10'd6) send_byte(frame_byte(cnt));
          else begin
            ph = PhPollR1;
            send_byte(ByteIdle);
          end
        end
        PhPollR1: begin
          if (m == ByteIdle) send_byte(ByteIdle);
          else on_r1(m);
        end
        PhR7: begin
          if (cnt >= 10'd3) begin
            if (m != ByteEcho) end_op(StEchoBad);
            else release_then(CmdAppCmd);
          end else begin
            cnt = cnt + 10'd1;
            send_byte(ByteIdle);
          end
        end
        PhWrBlock: begin
          if (cnt >= BlockCrcEnd) begin
            ph = PhWrResp;
            send_byte(ByteIdle);
          end else begin
            block_byte(cnt + 10'd1, wb);
          end
        end
        PhWrResp: begin
          if (m[4:0] != DataRespOk) end_op(StDataRejected);
          else begin
            ph = PhWrBusy;
            send_byte(ByteIdle);
          end
        end
        PhWrBusy: begin
          if (m == CardBusy) send_byte(ByteIdle);
          else release_done();
        end
        PhRdWait: begin
          if (m != ByteToken) send_byte(ByteIdle);
          else begin
            cnt = '0;
            ph = PhRdData;
            send_byte(ByteIdle);
          end
        end
        PhRdData: begin
          if (cnt < length) begin
            nxt.read_byte = m;
            nxt.read_valid = 1'b1;
          end
          if (cnt >= BlockLast) release_done();
          else begin
            cnt = cnt + 10'd1;
            send_byte(ByteIdle);
          end
        end
        PhRelDone: end_op(StOk);
        default: ;
      endcase
    endfunction

    function res_t predict_reply(host_beat_t b);
      nxt = '0;
      if (b.func == FuncStart) begin
        if (ph == PhIdle) on_start(b.op, b.addr, b.len);
      end else if (ph != PhIdle) begin
        on_done(b.miso, b.wb);
      end
      nxt.cs_level = sel;
      return nxt;
    endfunction

    function void note_beat(host_beat_t b);
      expected_replies.push_back(predict_reply(b));
    endfunction

    function string show(res_t r);
      return $sformatf("mosi %h/%b cs %b read %h/%b need %b done %b status %0d",
                       r.mosi_byte, r.mosi_valid, r.cs_level, r.read_byte, r.read_valid,
                       r.need_data, r.done_res, r.status);
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("ERROR: %s", msg);
    endfunction

    function void check_result(res_t got);
      res_t  want;
      string diff;
      checked++;
      if (expected_replies.size() == 0) begin
        flag($sformatf("result beat %0d with nothing pending: %s", checked, show(got)));
        return;
      end
      want = expected_replies.pop_front();
      diff = "";
      if (got.mosi_byte !== want.mosi_byte) diff = {diff, " mosi_byte"};
      if (got.mosi_valid !== want.mosi_valid) diff = {diff, " mosi_valid"};
      if (got.cs_level !== want.cs_level) diff = {diff, " cs_level"};
      if (got.read_byte !== want.read_byte) diff = {diff, " read_byte"};
      if (got.read_valid !== want.read_valid) diff = {diff, " read_valid"};
      if (got.need_data !== want.need_data) diff = {diff, " need_data"};
      if (got.done_res !== want.done_res) diff = {diff, " done_res"};
      if (got.status !== want.status) diff = {diff, " status"};
      if (diff != "")
        flag($sformatf("result beat %0d differs in%s\n  expected %s\n  actual   %s",
                       checked, diff, show(want), show(got)));
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_func = 1'b0;
  logic [1:0] in_op = '0;
  logic [8:0] in_addr = '0;
  logic [9:0] in_len = '0;
  logic [7:0] in_miso_byte = '0;
  logic [7:0] in_write_byte = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_mosi_byte;
  logic       out_mosi_valid;
  logic       out_cs_level;
  logic [7:0] out_read_byte;
  logic       out_read_valid;
  logic       out_need_data;
  logic       out_done_res;
  logic [2:0] out_status;

  sdsm_scoreboard sb;
  int in_calm = 0;
  int out_calm = 0;
  int items_sent = 0;

  sd_spi_shared_memory_host dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_op         (in_op),
    .in_addr       (in_addr),
    .in_len        (in_len),
    .in_miso_byte  (in_miso_byte),
    .in_write_byte (in_write_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_mosi_byte (out_mosi_byte),
    .out_mosi_valid(out_mosi_valid),
    .out_cs_level  (out_cs_level),
    .out_read_byte (out_read_byte),
    .out_read_valid(out_read_valid),
    .out_need_data (out_need_data),
    .out_done_res  (out_done_res),
    .out_status    (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // idle cycles before a beat; now and then a run of back-to-back beats
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  function automatic host_beat_t random_beat(logic func);
    host_beat_t b;
    b.func = func;
    b.op = 2'($urandom_range(0, 3));
    b.addr = 9'($urandom_range(0, 511));
    b.len = 10'($urandom_range(0, 1023));
    b.miso = 8'($urandom_range(0, 255));
    b.wb = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // card side: mostly well-behaved answers, sometimes a wrong one
  function automatic logic [7:0] card_reply();
    logic [7:0] noise;
    noise = 8'($urandom_range(0, 255));
    case (sb.ph)
      PhPollR1: begin
        if ($urandom_range(0, 2) == 0) return ByteIdle;
        if (sb.cmd == CmdGoIdle || sb.cmd == CmdSendIfCond)
          return ($urandom_range(0, 7) == 0) ? noise : ByteR1Idle;
        if (sb.cmd == CmdSendOpCond) return ($urandom_range(0, 1) == 0) ? ByteR1Idle : R1Ready;
        if (sb.cmd == CmdAppCmd) return noise;
        return ($urandom_range(0, 9) == 0) ? noise : R1Ready;
      end
      PhR7: return (sb.cnt >= 10'd3 && $urandom_range(0, 7) != 0) ? ByteEcho : noise;
      PhWrResp: return ($urandom_range(0, 7) == 0) ? noise : {noise[7:5], DataRespOk};
      PhWrBusy: return ($urandom_range(0, 1) == 0) ? CardBusy : noise;
      PhRdWait: return ($urandom_range(0, 2) == 0) ? ByteToken : noise;
      default: return noise;
    endcase
  endfunction

  task automatic send_beat(input host_beat_t b, input bit counted);
    int gap;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= b.func;
    in_op <= b.op;
    in_addr <= b.addr;
    in_len <= b.len;
    in_miso_byte <= b.miso;
    in_write_byte <= b.wb;
    do @(posedge clk); while (!in_ready);
    sb.note_beat(b);
    if (counted) items_sent++;
  endtask

  // an operation still running when the item budget is spent is left unfinished
  task automatic run_operation(input host_beat_t start, input bit busy_start);
    host_beat_t b;
    send_beat(start, 1'b1);
    if (busy_start && sb.ph != PhIdle) send_beat(random_beat(FuncStart), 1'b0);
    while (sb.ph != PhIdle && items_sent < ItemCount) begin
      if ($urandom_range(0, 29) == 0) send_beat(random_beat(FuncStart), 1'b0);
      b = random_beat(FuncDone);
      b.miso = card_reply();
      send_beat(b, 1'b1);
    end
  endtask

  initial begin
    host_beat_t b;
    int         pick;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // done beat while idle, all fields at their top
    b = '{func: FuncDone, op: OpUnused, addr: 9'h1FF, len: 10'h3FF, miso: 8'hFF, wb: 8'hFF};
    send_beat(b, 1'b0);
    b = '{func: FuncStart, op: OpWrite, addr: 9'd0, len: 10'd0, miso: 8'h00, wb: 8'h00};
    run_operation(b, 1'b0);
    b.addr = 9'd511;
    b.len = 10'd2;
    run_operation(b, 1'b0);
    b = '{func: FuncStart, op: OpRead, addr: 9'd0, len: 10'd513, miso: 8'hFF, wb: 8'hFF};
    run_operation(b, 1'b0);
    b.addr = 9'd511;
    b.len = 10'h3FF;
    run_operation(b, 1'b0);
    b = '{func: FuncStart, op: OpUnused, addr: 9'd0, len: 10'd1, miso: 8'h00, wb: 8'h00};
    run_operation(b, 1'b0);
    b = '{func: FuncStart, op: OpInit, addr: 9'h1FF, len: 10'h3FF, miso: 8'h00, wb: 8'h00};
    run_operation(b, 1'b1);

    while (items_sent < ItemCount) begin
      if ($urandom_range(0, 9) == 0) send_beat(random_beat(FuncDone), 1'b0);
      pick = $urandom_range(0, 9);
      b = random_beat(FuncStart);
      if (pick < 3) begin
        b.op = OpInit;
      end else if (pick <= 8) begin
        b.op = (pick <= 5) ? OpWrite : OpRead;
        case ($urandom_range(0, 7))
          0: begin
            b.addr = 9'd0;
            b.len = BlockBytes;
          end
          1: begin
            b.addr = 9'd511;
            b.len = 10'd1;
          end
          default: begin
            b.addr = 9'($urandom_range(0, 511));
            b.len = 10'($urandom_range(1, 512 - b.addr));
          end
        endcase
      end
      run_operation(b, 1'b0);
    end

    in_valid <= 1'b0;
    while (sb.expected_replies.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (sb.errors == 0) $display("tb_sd_spi_shared_memory_host passed");
    else $display("tb_sd_spi_shared_memory_host failed");
    $finish;
  end

  initial begin
    int gap;
    wait (rst_n === 1'b1);
    forever begin
      gap = draw_gap(out_calm);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (out_valid && out_ready)
      sb.check_result(res_t'({out_mosi_byte, out_mosi_valid, out_cs_level, out_read_byte,
                              out_read_valid, out_need_data, out_done_res, out_status}));
  end

  initial begin
    #10_000_000;
    $display("tb_sd_spi_shared_memory_host failed");
    $finish;
  end

endmodule
